### sv/sliding_window_median_top_defines.svh
// ----------------------------------------------------------------------------
// Sliding window median - assertion macros
// Concurrent check macros shared by the RTL files; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define SWM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sliding window median check failed");
// Check that a condition holds in the cycle after a trigger
`define SWM_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("sliding window median sequence check failed");
`else
`define SWM_ASSERT(lbl, prop)
`define SWM_ASSERT_NEXT(lbl, trig, cond)
`endif

`endif

### sv/swm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window median - package
// Field widths and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

  localparam int unsigned SAMPLE_W = 10;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;   // capture the incoming sample
    logic del;      // shift arrival line, drop oldest from sorted row once full
    logic ins;      // insert captured sample into sorted row
    logic rd_a;     // read upper middle entry
    logic rd_b;     // read lower middle entry
    logic load;     // load the output register
  } swm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free; // output register can take a new result
  } swm_sts_t;

endpackage

`default_nettype wire

### sv/swm_ctrl.sv
// ----------------------------------------------------------------------------
// Sliding window median - controller
// Sequences accept, delete, insert, two middle reads and result load.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sliding_window_median_top_defines.svh"

module swm_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  swm_pkg::swm_sts_t     sts_i,
  output swm_pkg::swm_cmd_t     cmd_o
);
  import swm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DEL  = 6'b000010,
    S_INS  = 6'b000100,
    S_RDA  = 6'b001000,
    S_RDB  = 6'b010000,
    S_DONE = 6'b100000
  } swm_state_e;

  swm_state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DEL;
        end
      end
      S_DEL: begin
        cmd_o.del = 1'b1;
        state_d   = S_INS;
      end
      S_INS: begin
        cmd_o.ins = 1'b1;
        state_d   = S_RDA;
      end
      S_RDA: begin
        cmd_o.rd_a = 1'b1;
        state_d    = S_RDB;
      end
      S_RDB: begin
        cmd_o.rd_b = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `SWM_ASSERT_NEXT(a_accept_to_del, cmd_o.accept, state_q == S_DEL)
  `SWM_ASSERT_NEXT(a_load_to_idle, cmd_o.load, state_q == S_IDLE)
  `SWM_ASSERT(a_state_onehot, $onehot(state_q))

endmodule

`default_nettype wire

### sv/swm_dpath.sv
// ----------------------------------------------------------------------------
// Sliding window median - datapath
// Arrival shift line, sorted row of lanes, middle reads and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sliding_window_median_top_defines.svh"

module swm_dpath #(
  parameter int unsigned WINDOW = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  swm_pkg::swm_cmd_t                 cmd_i,
  output swm_pkg::swm_sts_t                 sts_o,
  input  wire logic [swm_pkg::SAMPLE_W-1:0] sample_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [swm_pkg::SAMPLE_W-1:0] median_o,
  output logic                              ready_res_o
);
  import swm_pkg::*;

  localparam int unsigned IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW = $clog2(WINDOW + 1);

  logic [SAMPLE_W-1:0] win_q [WINDOW];   // arrival order, newest at 0
  logic [SAMPLE_W-1:0] srt_q [WINDOW];   // ascending sorted copy
  logic [SAMPLE_W-1:0] del_nx [WINDOW];
  logic [SAMPLE_W-1:0] ins_nx [WINDOW];
  logic [WINDOW-1:0]   ge;
  logic [WINDOW-1:0]   gtv;
  logic [SAMPLE_W-1:0] smp_q;
  logic [SAMPLE_W-1:0] hi_q;
  logic [SAMPLE_W-1:0] lo_q;
  logic [SAMPLE_W-1:0] med_q;
  logic                rdy_q;
  logic                ovalid_q;
  logic [CW-1:0]       cnt_q;
  logic                full;
  logic [SAMPLE_W-1:0] oldest;
  logic [IW-1:0]       mid;
  logic [IW-1:0]       rd_idx;
  logic [SAMPLE_W-1:0] rd_val;
  logic [SAMPLE_W:0]   pair_sum;
  logic                enough;

  assign full   = (cnt_q == CW'(WINDOW));
  assign oldest = win_q[WINDOW-1];
  assign enough = (cnt_q >= CW'(2));

  // Per-lane delete and insert moves on the sorted row
  for (genvar i = 0; i < WINDOW; i++) begin : g_lane
    assign ge[i]  = (srt_q[i] >= oldest);
    assign gtv[i] = (CW'(i + 1) >= cnt_q) || (srt_q[i] > smp_q);
    if (i < WINDOW - 1) begin : g_del_shift
      assign del_nx[i] = ge[i] ? srt_q[i+1] : srt_q[i];
    end else begin : g_del_last
      assign del_nx[i] = srt_q[i];
    end
    if (i == 0) begin : g_ins_first
      assign ins_nx[i] = gtv[i] ? smp_q : srt_q[i];
    end else begin : g_ins_rest
      assign ins_nx[i] = gtv[i] ? (gtv[i-1] ? srt_q[i-1] : smp_q) : srt_q[i];
    end
  end

  // One middle entry per cycle: upper middle, then lower (same one if odd)
  assign mid      = IW'(cnt_q >> 1);
  assign rd_idx   = (cmd_i.rd_a || cnt_q[0]) ? mid : (mid - IW'(1));
  assign rd_val   = srt_q[rd_idx];
  assign pair_sum = {1'b0, hi_q} + {1'b0, lo_q};

  // Hold sample, shift arrival line, update sorted row and reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      smp_q <= sample_i;
    end
    if (cmd_i.del) begin
      win_q[0] <= smp_q;
      for (int unsigned k = 1; k < WINDOW; k++) begin
        win_q[k] <= win_q[k-1];
      end
      if (full) begin
        srt_q <= del_nx;
      end
    end
    if (cmd_i.ins) begin
      srt_q <= ins_nx;
    end
    if (cmd_i.rd_a) begin
      hi_q <= rd_val;
    end
    if (cmd_i.rd_b) begin
      lo_q <= rd_val;
    end
    if (cmd_i.load) begin
      med_q <= enough ? pair_sum[SAMPLE_W:1] : '0;
      rdy_q <= enough;
    end
  end

  // Advance fill count until the window is full
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.del && !full) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  // Output register valid: set on load, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.load) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  assign sts_o.out_free = !ovalid_q || out_ready_i;
  assign out_valid_o    = ovalid_q;
  assign median_o       = med_q;
  assign ready_res_o    = rdy_q;

  `SWM_ASSERT(a_cnt_max, cnt_q <= CW'(WINDOW))
  `SWM_ASSERT(a_not_ready_zero, (ovalid_q && !rdy_q) |-> (med_q == '0))
  `SWM_ASSERT_NEXT(a_cnt_grows, cmd_i.del && !full, cnt_q != $past(cnt_q))

endmodule

`default_nettype wire

### sv/sliding_window_median_top.sv
// ----------------------------------------------------------------------------
// Sliding window median - top level
// Median of the last WINDOW ADC samples, one result per accepted sample.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata fields (low bit up)  | tuser
//  s_axis    | in  | sample[9:0], zero pad      | -
//  m_axis    | out | median_value[9:0], zero pad| ready_res
//
//  Each sample runs through the sequencer steps accept, delete oldest,
//  insert, two middle reads and load; the result is valid once loaded, and
//  the next sample is taken only after the previous result has been loaded.
//  A result waits in the output register while the next sample is accepted.
//  A stalled m_axis holds the sequencer in its last step until space frees.
//  Reset clears the fill count, output valid and control state; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median_top #(
  parameter int unsigned WINDOW = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [9:0] sample, [15:10] zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,   // [9:0] median_value, [15:10] zero
  output logic             m_axis_tuser    // [0] ready_res
);
  import swm_pkg::*;

  swm_cmd_t            cmd;
  swm_sts_t            sts;
  logic [SAMPLE_W-1:0] median;

  // Sequencer
  swm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Window storage, ranking and output register
  swm_dpath #(
    .WINDOW (WINDOW)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (s_axis_tdata[SAMPLE_W-1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .median_o    (median),
    .ready_res_o (m_axis_tuser)
  );

  // Pad the result to whole bytes
  assign m_axis_tdata = {{(16 - SAMPLE_W){1'b0}}, median};

endmodule

`default_nettype wire
